### rtl/like_pattern_matcher_defines.svh
// Assertion macros for the checker file of the LIKE matcher.
`ifndef LIKE_PATTERN_MATCHER_DEFINES_SVH
`define LIKE_PATTERN_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while reset is held
`define LPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is held
`define LPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

    // Fixed field and register geometry
    localparam int PATTERN_MAX_DEF = 32;
    localparam int BYTE_W          = 8;
    localparam int WORD_BYTES      = 8;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int LEN_W           = 6;

    // Wildcard bytes
    localparam logic [BYTE_W-1:0] ANY_RUN = 8'h25;
    localparam logic [BYTE_W-1:0] ANY_ONE = 8'h5F;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD_0 = 3'd1,
        REG_PATTERN_WORD_1 = 3'd2,
        REG_PATTERN_WORD_2 = 3'd3,
        REG_PATTERN_WORD_3 = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

### rtl/lpm_closure.sv
`default_nettype none

// Spread alive positions forward across runs of '%'. This is a carry chain:
// closed[i] = alive[i] | (prop[i] & closed[i-1]), solved with a parallel
// prefix network of ceil(log2(WIDTH)) levels.
module lpm_closure #(
    parameter int WIDTH = 33
) (
    input  wire logic [WIDTH-1:0] alive_i,
    input  wire logic [WIDTH-1:0] prop_i,
    output logic      [WIDTH-1:0] closed_o
);

    localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] gen_lvl  [LEVELS+1];
    logic [WIDTH-1:0] prop_lvl [LEVELS+1];

    assign gen_lvl[0]  = alive_i;
    assign prop_lvl[0] = prop_i;

    // Combine spans of doubling distance at each level
    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        localparam int DIST = 1 << l;
        always_comb begin
            for (int i = 0; i < WIDTH; i++) begin
                if (i >= DIST) begin
                    gen_lvl[l+1][i]  = gen_lvl[l][i] | (prop_lvl[l][i] & gen_lvl[l][i-DIST]);
                    prop_lvl[l+1][i] = prop_lvl[l][i] & prop_lvl[l][i-DIST];
                end else begin
                    gen_lvl[l+1][i]  = gen_lvl[l][i];
                    prop_lvl[l+1][i] = prop_lvl[l][i];
                end
            end
        end
    end

    assign closed_o = gen_lvl[LEVELS];

endmodule

`default_nettype wire

### rtl/like_pattern_matcher.sv
`default_nettype none

// SQL LIKE matcher: the pattern ('%' any run, '_' any one byte, no escape) is
// loaded through the cfg_* write port, then text streams in one byte per
// transaction on s_*, the last one flagged by s_final_byte (an item with
// s_no_byte set carries no byte and stands for an empty text when final).
// One m_matched transaction follows each final item; other items give none.
// Throughput is one byte per cycle while s_ready is high: the update of the
// per-position alive bits, a prefix network over the '%' runs plus a byte
// compare per position, is combinational. The state of a final item is
// registered in the judge stage, which runs the final '%' closure and the
// length select; the result then moves into the output register, raising m_valid.
// s_ready drops only while both the judge stage and the output register are
// full and m_ready is low.
module like_pattern_matcher #(
    parameter int PATTERN_MAX = lpm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [lpm_pkg::BYTE_W-1:0]      s_text_byte,
    input  wire logic                            s_no_byte,
    input  wire logic                            s_final_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_matched
);

    import lpm_pkg::*;

    localparam int VEC_W     = PATTERN_MAX + 1;
    localparam int LEN_IDX_W = $clog2(PATTERN_MAX + 1);

    logic [BYTE_W-1:0]    pattern_reg [PATTERN_MAX];
    logic [LEN_W-1:0]     pattern_length_reg;
    logic [LEN_IDX_W-1:0] len_used;
    logic [PATTERN_MAX-1:0] used_mask;
    logic [VEC_W-1:0]     prop_vec;

    logic [VEC_W-1:0]     alive_reg;
    logic [VEC_W-1:0]     alive_next;
    logic [VEC_W-1:0]     closed_a;
    logic [VEC_W-1:0]     step_vec;

    logic                 judge_valid_reg;
    logic                 judge_valid_next;
    logic [VEC_W-1:0]     judge_vec_reg;
    logic [VEC_W-1:0]     closed_b;
    logic                 judge_take;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic                 m_matched_reg;
    logic                 s_accept;

    // Pattern length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
        end else if (cfg_wr_en && cfg_index == REG_PATTERN_LENGTH) begin
            pattern_length_reg <= cfg_data[LEN_W-1:0];
        end
    end

    // Pattern bytes, each taken from its lane of its word register
    for (genvar b = 0; b < PATTERN_MAX; b++) begin : g_pat
        localparam int WORD_SEL = b / WORD_BYTES;
        localparam int LANE     = b % WORD_BYTES;
        localparam logic [CFG_IDX_W-1:0] WORD_IDX =
            CFG_IDX_W'(int'(REG_PATTERN_WORD_0) + WORD_SEL);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pattern_reg[b] <= '0;
            end else if (cfg_wr_en && cfg_index == WORD_IDX) begin
                pattern_reg[b] <= cfg_data[LANE*BYTE_W +: BYTE_W];
            end
        end
    end

    // Saturate the length and mark positions in use
    assign len_used = (pattern_length_reg > LEN_W'(PATTERN_MAX)) ?
                      LEN_IDX_W'(PATTERN_MAX) : pattern_length_reg[LEN_IDX_W-1:0];

    always_comb begin
        prop_vec = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            used_mask[i]  = LEN_IDX_W'(i) < len_used;
            prop_vec[i+1] = used_mask[i] && (pattern_reg[i] == ANY_RUN);
        end
    end

    // Stage A: close the held state over '%' runs, then consume the byte
    lpm_closure #(.WIDTH(VEC_W)) u_closure_a (
        .alive_i  (alive_reg),
        .prop_i   (prop_vec),
        .closed_o (closed_a)
    );

    always_comb begin
        step_vec = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (used_mask[i] && closed_a[i]) begin
                if (pattern_reg[i] == ANY_RUN) begin
                    step_vec[i] = 1'b1;
                end else if (pattern_reg[i] == ANY_ONE || pattern_reg[i] == s_text_byte) begin
                    step_vec[i+1] = 1'b1;
                end
            end
        end
        // An item without a byte leaves the state as it is
        if (s_no_byte) begin
            step_vec = alive_reg;
        end
    end

    assign judge_take = !m_valid_reg || m_ready;
    assign s_ready    = !judge_valid_reg || judge_take;
    assign s_accept   = s_valid && s_ready;

    // Advance the alive state; a final item hands its state to the judge stage
    always_comb begin
        alive_next       = alive_reg;
        judge_valid_next = judge_valid_reg && !judge_take;
        if (s_accept) begin
            if (s_final_byte) begin
                alive_next       = VEC_W'(1);
                judge_valid_next = 1'b1;
            end else begin
                alive_next = step_vec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg       <= VEC_W'(1);
            judge_valid_reg <= 1'b0;
        end else begin
            alive_reg       <= alive_next;
            judge_valid_reg <= judge_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_final_byte) begin
            judge_vec_reg <= step_vec;
        end
    end

    // Stage B: final closure and pick the bit at the pattern length
    lpm_closure #(.WIDTH(VEC_W)) u_closure_b (
        .alive_i  (judge_vec_reg),
        .prop_i   (prop_vec),
        .closed_o (closed_b)
    );

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (judge_valid_reg && judge_take) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (judge_valid_reg && judge_take) begin
            m_matched_reg <= closed_b[len_used];
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;

endmodule

`default_nettype wire

### rtl/lpm_checker.sv
`default_nettype none

`include "like_pattern_matcher_defines.svh"

// Port-level checks of the matcher's result timing and flow control
module lpm_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           s_final_byte,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic                           m_matched
);

    // A new result only shows up after a final transaction has passed the judge stage
    `LPM_ASSERT_NOW(a_result_from_final, $rose(m_valid), $past(s_valid && s_ready && s_final_byte, 2), "result without a final transaction")

    // A final transaction taken while the output is empty gives a result after the judge stage
    `LPM_ASSERT_NOW(a_final_gives_result, s_valid && s_ready && s_final_byte && !m_valid, ##2 m_valid, "final transaction gave no result")

    // Input is never held off while the output register is empty
    `LPM_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready, "input stalled with output empty")

    // Hold a stalled result
    `LPM_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_matched), "stalled result changed")

endmodule

bind like_pattern_matcher lpm_checker u_lpm_checker (.*);

`default_nettype wire
